// File: rtl/sc1kd_pkg.sv
`default_nettype none

package sc1kd_pkg;

	// Scancode set 1 framing constants
	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam int         BREAK_BIT   = 7;

	// Extended cursor key codes
	localparam logic [7:0] KEY_LEFT  = 8'hFA;
	localparam logic [7:0] KEY_RIGHT = 8'hFB;
	localparam logic [7:0] KEY_HOME  = 8'hFC;
	localparam logic [7:0] KEY_UP    = 8'hFD;
	localparam logic [7:0] KEY_DOWN  = 8'hFE;

	// Make codes (low seven bits) of the cursor keys
	localparam logic [6:0] SC_HOME  = 7'h47;
	localparam logic [6:0] SC_UP    = 7'h48;
	localparam logic [6:0] SC_LEFT  = 7'h4B;
	localparam logic [6:0] SC_RIGHT = 7'h4D;
	localparam logic [6:0] SC_DOWN  = 7'h50;

	// Decoded item carried from the input stage to the result register
	typedef struct packed {
		logic       emit;
		logic [7:0] code;
		logic       press;
	} sc1kd_evt_t;

	// Cursor key translation after the extended prefix; zero means no event
	function automatic logic [7:0] cursor_code(input logic [6:0] low7);
		logic [7:0] c;
		case (low7)
			SC_LEFT:  c = KEY_LEFT;
			SC_RIGHT: c = KEY_RIGHT;
			SC_HOME:  c = KEY_HOME;
			SC_UP:    c = KEY_UP;
			SC_DOWN:  c = KEY_DOWN;
			default:  c = 8'h00;
		endcase
		return c;
	endfunction

	// Normal key table; zero means unmapped
	function automatic logic [7:0] key_table(input logic [6:0] low7);
		logic [7:0] c;
		case (low7)
			7'h01: c = 8'h01;
			7'h02: c = "1";
			7'h03: c = "2";
			7'h04: c = "3";
			7'h05: c = "4";
			7'h06: c = "5";
			7'h07: c = "6";
			7'h08: c = "7";
			7'h09: c = "8";
			7'h0A: c = "9";
			7'h0B: c = "0";
			7'h0C: c = "-";
			7'h0D: c = "=";
			7'h0E: c = 8'h0E;
			7'h0F: c = 8'h0F;
			7'h10: c = "Q";
			7'h11: c = "W";
			7'h12: c = "E";
			7'h13: c = "R";
			7'h14: c = "T";
			7'h15: c = "Y";
			7'h16: c = "U";
			7'h17: c = "I";
			7'h18: c = "O";
			7'h19: c = "P";
			7'h1A: c = "[";
			7'h1B: c = "]";
			7'h1C: c = 8'h0A;
			7'h1D: c = 8'h1D;
			7'h1E: c = "A";
			7'h1F: c = "S";
			7'h20: c = "D";
			7'h21: c = "F";
			7'h22: c = "G";
			7'h23: c = "H";
			7'h24: c = "J";
			7'h25: c = "K";
			7'h26: c = "L";
			7'h27: c = ";";
			7'h28: c = 8'h27;
			7'h29: c = 8'h60;
			7'h2A: c = 8'h2A;
			7'h2B: c = 8'h2B;
			7'h2C: c = "Z";
			7'h2D: c = "X";
			7'h2E: c = "C";
			7'h2F: c = "V";
			7'h30: c = "B";
			7'h31: c = "N";
			7'h32: c = "M";
			7'h33: c = ",";
			7'h34: c = ".";
			7'h35: c = "/";
			7'h36: c = 8'h2A;
			7'h37: c = "*";
			7'h38: c = 8'hFF;
			7'h39: c = " ";
			7'h3B: c = 8'hF1;
			7'h3C: c = 8'hF2;
			7'h3D: c = 8'hF3;
			7'h3E: c = 8'hF4;
			7'h3F: c = 8'hF5;
			7'h40: c = 8'hF6;
			7'h41: c = 8'hF7;
			7'h42: c = 8'hF8;
			7'h43: c = 8'h02;
			7'h44: c = 8'h03;
			7'h45: c = 8'h91;
			7'h46: c = 8'h90;
			7'h47: c = KEY_HOME;
			7'h48: c = KEY_UP;
			7'h4B: c = KEY_LEFT;
			7'h4D: c = KEY_RIGHT;
			7'h50: c = KEY_DOWN;
			7'h58: c = 8'h04;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/scancode_set1_key_decoder_top.sv
`default_nettype none

// Scancode set 1 key decoder: takes one raw keyboard byte per transfer on the
// input channel and gives at most one key event (key_code, is_press) on the
// output channel. Byte 0xE0 arms the extended prefix; the byte after it yields
// a cursor key (0xFA..0xFE) or nothing. Other bytes go through the fixed key
// table, bit 7 marking a release; unmapped bytes yield nothing. With
// events_enabled low (written through the cfg channel, reset value 1) every
// byte is dropped and the prefix is cleared. A byte is registered in an input
// stage and decoded from there into the result register, so the block takes
// one byte every cycle; out_valid rises from the result register once the byte
// has passed the input stage, and only a stalled result register, while the byte
// in the input stage yields an event, stops the flow. cfg_ready is always high.
module scancode_set1_key_decoder_top
	import sc1kd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] scan_byte,

	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      key_code,
	output logic            is_press,

	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);

	logic       events_en_q;
	logic       pend_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic [7:0] code_q;
	logic       press_q;

	sc1kd_evt_t evt;
	logic       pend_d;
	logic       adv_s1;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			events_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			events_en_q <= cfg_data;
		end
	end

	// Decode of the byte in the input stage
	always_comb begin
		evt.emit  = 1'b0;
		evt.code  = 8'h00;
		evt.press = ~byte_s1[BREAK_BIT];
		pend_d    = pend_q;
		if (!events_en_q) begin
			pend_d = 1'b0;
		end else if (pend_q) begin
			pend_d   = 1'b0;
			evt.code = cursor_code(byte_s1[6:0]);
			evt.emit = (evt.code != 8'h00);
		end else if (byte_s1 == PREFIX_BYTE) begin
			pend_d = 1'b1;
		end else begin
			evt.code = key_table(byte_s1[6:0]);
			evt.emit = (evt.code != 8'h00);
		end
	end

	// Stage advances when its event can land in the result register
	assign adv_s1   = valid_s1 && (!evt.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input stage and prefix flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			if (adv_s1) begin
				pend_q <= pend_d;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= scan_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && evt.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && evt.emit) begin
			code_q  <= evt.code;
			press_q <= evt.press;
		end
	end

	assign out_valid = out_valid_q;
	assign key_code  = code_q;
	assign is_press  = press_q;

	// Checks
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> key_code != 8'h00)
		else $error("result with zero key code");

	a_prefix_arms: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && events_en_q && !pend_q && byte_s1 == PREFIX_BYTE |=> pend_q)
		else $error("prefix byte did not arm extended flag");

	a_prefix_once: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && pend_q |=> !pend_q)
		else $error("extended flag survived the byte after prefix");

	a_disabled_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !events_en_q |=> !pend_q && !$rose(out_valid_q))
		else $error("byte not dropped while events disabled");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && evt.emit |=> out_valid_q)
		else $error("decoded event lost");

endmodule

`default_nettype wire
